// ===== rtl/obb_pkg.sv =====
// shared constants, types and arithmetic helpers of the basis builder
package obb_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int COMP_W      = 32;
    localparam int CFG_W       = 63;

    // long division: 64-bit divisor, 32 quotient bits, one bit per stage
    localparam int DSR_W       = 64;
    localparam int QUO_W       = 32;
    localparam int DVD_W       = DSR_W + QUO_W;
    localparam int DIV_STAGES  = QUO_W;

    // square root: 64-bit radicand, 32 root bits, one bit per stage
    localparam int SQ_IN_W     = 64;
    localparam int SQ_OUT_W    = 32;
    localparam int SQ_REM_W    = SQ_OUT_W + 2;
    localparam int SQRT_STAGES = SQ_OUT_W;

    // input and output registers, four front stages, eight middle stages
    localparam int PIPE_DEPTH  = 14 + 2 * DIV_STAGES + SQRT_STAGES;

    localparam logic [CFG_W-1:0] THR_RESET = CFG_W'(1);
    localparam logic [CFG_W-1:0] TOL_RESET = CFG_W'(43);

    localparam logic signed [COMP_W-1:0] UNIT_POS = COMP_W'(1) <<< FRAC_BITS;
    localparam logic signed [COMP_W-1:0] UNIT_NEG = -UNIT_POS;

    localparam logic signed [64:0] SAT_HI = 65'sh0_7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [64:0] SAT_LO = -SAT_HI;
    localparam logic signed [65:0] COMP_HI = (66'sd1 <<< (COMP_W - 1)) - 66'sd1;
    localparam logic signed [65:0] COMP_LO = -(66'sd1 <<< (COMP_W - 1));

    // operand order of the cross product terms
    localparam int unsigned NXT1 [3] = '{1, 2, 0};
    localparam int unsigned NXT2 [3] = '{2, 0, 1};

    typedef enum logic {
        CFG_PARALLEL  = 1'b0,
        CFG_TOLERANCE = 1'b1
    } cfg_idx_e;

    typedef logic [COMP_W-1:0] comp_t;
    typedef comp_t [2:0]       vec_t;
    typedef vec_t [2:0]        basis_t;

    typedef struct packed {
        vec_t [1:0]       v;
        vec_t             z;
        logic [1:0][2:0]  neg;
        logic             zz0;
    } proj_side_t;

    typedef struct packed {
        basis_t     b;
        logic [2:0] nf;
    } norm_side_t;

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = $signed({a[63], a}) + $signed({b[63], b});
        if (s > SAT_HI)
        begin
            return SAT_HI[63:0];
        end
        else if (s < SAT_LO)
        begin
            return SAT_LO[63:0];
        end
        return s[63:0];
    endfunction

    function automatic comp_t clamp_comp(input logic signed [65:0] v);
        if (v > COMP_HI)
        begin
            return COMP_HI[COMP_W-1:0];
        end
        else if (v < COMP_LO)
        begin
            return COMP_LO[COMP_W-1:0];
        end
        return v[COMP_W-1:0];
    endfunction

    function automatic comp_t cross_term(input logic signed [63:0] ab,
                                         input logic signed [63:0] cd);
        logic signed [63:0] diff;
        logic signed [63:0] sh;
        logic signed [65:0] w;
        diff = sat_add(ab, -cd);
        sh   = diff >>> FRAC_BITS;
        w    = sh;
        return clamp_comp(w);
    endfunction

    function automatic comp_t mag_comp(input comp_t v);
        return v[COMP_W-1] ? COMP_W'(0) - v : v;
    endfunction

endpackage

// ===== rtl/obb_div.sv =====
// pipelined restoring divider, one quotient bit per stage
module obb_div (
    input  logic                         clk,
    input  logic                         en,
    input  logic [obb_pkg::DVD_W-1:0]    dividend,
    input  logic [obb_pkg::DSR_W-1:0]    divisor,
    output logic [obb_pkg::QUO_W-1:0]    quotient
);
    import obb_pkg::*;

    logic [DSR_W-1:0] rem_reg  [DIV_STAGES];
    logic [DSR_W-1:0] rem_next [DIV_STAGES];
    logic [QUO_W-1:0] low_reg  [DIV_STAGES];
    logic [QUO_W-1:0] low_next [DIV_STAGES];
    logic [QUO_W-1:0] quo_reg  [DIV_STAGES];
    logic [QUO_W-1:0] quo_next [DIV_STAGES];
    logic [DSR_W-1:0] dsr_reg  [DIV_STAGES];
    logic [DSR_W-1:0] dsr_next [DIV_STAGES];

    always_comb
    begin
        logic [DSR_W-1:0] s_rem;
        logic [QUO_W-1:0] s_low;
        logic [QUO_W-1:0] s_quo;
        logic [DSR_W-1:0] s_dsr;
        logic [DSR_W:0]   trial;
        for (int i = 0; i < DIV_STAGES; i++)
        begin
            if (i == 0)
            begin
                // upper part stays below the divisor since the quotient fits
                s_rem = dividend[DVD_W-1 -: DSR_W];
                s_low = dividend[QUO_W-1:0];
                s_quo = '0;
                s_dsr = divisor;
            end
            else
            begin
                s_rem = rem_reg[i-1];
                s_low = low_reg[i-1];
                s_quo = quo_reg[i-1];
                s_dsr = dsr_reg[i-1];
            end
            trial = {s_rem, s_low[QUO_W-1]};
            if (trial >= {1'b0, s_dsr})
            begin
                rem_next[i] = DSR_W'(trial - {1'b0, s_dsr});
                quo_next[i] = {s_quo[QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[i] = trial[DSR_W-1:0];
                quo_next[i] = {s_quo[QUO_W-2:0], 1'b0};
            end
            low_next[i] = {s_low[QUO_W-2:0], 1'b0};
            dsr_next[i] = s_dsr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < DIV_STAGES; i++)
            begin
                rem_reg[i] <= rem_next[i];
                low_reg[i] <= low_next[i];
                quo_reg[i] <= quo_next[i];
                dsr_reg[i] <= dsr_next[i];
            end
        end
    end

    assign quotient = quo_reg[DIV_STAGES-1];

endmodule

// ===== rtl/obb_isqrt.sv =====
// pipelined integer square root, one root bit per stage
module obb_isqrt (
    input  logic                          clk,
    input  logic                          en,
    input  logic [obb_pkg::SQ_IN_W-1:0]   radicand,
    output logic [obb_pkg::SQ_OUT_W-1:0]  root
);
    import obb_pkg::*;

    logic [SQ_REM_W-1:0] rem_reg   [SQRT_STAGES];
    logic [SQ_REM_W-1:0] rem_next  [SQRT_STAGES];
    logic [SQ_IN_W-1:0]  val_reg   [SQRT_STAGES];
    logic [SQ_IN_W-1:0]  val_next  [SQRT_STAGES];
    logic [SQ_OUT_W-1:0] root_reg  [SQRT_STAGES];
    logic [SQ_OUT_W-1:0] root_next [SQRT_STAGES];

    always_comb
    begin
        logic [SQ_REM_W-1:0] s_rem;
        logic [SQ_IN_W-1:0]  s_val;
        logic [SQ_OUT_W-1:0] s_root;
        logic [SQ_REM_W+1:0] cur;
        logic [SQ_REM_W+1:0] trial;
        for (int i = 0; i < SQRT_STAGES; i++)
        begin
            if (i == 0)
            begin
                s_rem  = '0;
                s_val  = radicand;
                s_root = '0;
            end
            else
            begin
                s_rem  = rem_reg[i-1];
                s_val  = val_reg[i-1];
                s_root = root_reg[i-1];
            end
            cur   = {s_rem, s_val[SQ_IN_W-1 -: 2]};
            trial = {2'b00, s_root, 2'b01};
            if (cur >= trial)
            begin
                rem_next[i]  = SQ_REM_W'(cur - trial);
                root_next[i] = {s_root[SQ_OUT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[i]  = cur[SQ_REM_W-1:0];
                root_next[i] = {s_root[SQ_OUT_W-2:0], 1'b0};
            end
            val_next[i] = {s_val[SQ_IN_W-3:0], 2'b00};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < SQRT_STAGES; i++)
            begin
                rem_reg[i]  <= rem_next[i];
                val_reg[i]  <= val_next[i];
                root_reg[i] <= root_next[i];
            end
        end
    end

    assign root = root_reg[SQRT_STAGES-1];

endmodule

// ===== rtl/orthonormal_basis_builder.sv =====
// Orthonormal basis builder: top level. Fully pipelined, it takes one request per
// clock unless the output stalls; a request passes 4 front stages, a 32-stage
// projection divider, 8 stages of replacement and length math, a 32-stage square
// root, a 32-stage normalizing divider and input and output registers. The whole pipe
// advances whenever the output register is empty or taken, so a stall on the output
// holds every stage in place. The two threshold registers are read live and should
// only be written while no request is in flight.
module orthonormal_basis_builder (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wen,
    input  obb_pkg::cfg_idx_e                   cfg_idx,
    input  logic [obb_pkg::CFG_W-1:0]           cfg_wdata,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [obb_pkg::COMP_W-1:0]   xa_x,
    input  logic signed [obb_pkg::COMP_W-1:0]   xa_y,
    input  logic signed [obb_pkg::COMP_W-1:0]   xa_z,
    input  logic signed [obb_pkg::COMP_W-1:0]   ya_x,
    input  logic signed [obb_pkg::COMP_W-1:0]   ya_y,
    input  logic signed [obb_pkg::COMP_W-1:0]   ya_z,
    input  logic signed [obb_pkg::COMP_W-1:0]   za_x,
    input  logic signed [obb_pkg::COMP_W-1:0]   za_y,
    input  logic signed [obb_pkg::COMP_W-1:0]   za_z,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [obb_pkg::COMP_W-1:0]   bx_x,
    output logic signed [obb_pkg::COMP_W-1:0]   bx_y,
    output logic signed [obb_pkg::COMP_W-1:0]   bx_z,
    output logic signed [obb_pkg::COMP_W-1:0]   by_x,
    output logic signed [obb_pkg::COMP_W-1:0]   by_y,
    output logic signed [obb_pkg::COMP_W-1:0]   by_z,
    output logic signed [obb_pkg::COMP_W-1:0]   bz_x,
    output logic signed [obb_pkg::COMP_W-1:0]   bz_y,
    output logic signed [obb_pkg::COMP_W-1:0]   bz_z,
    output logic                                x_normalized,
    output logic                                y_normalized,
    output logic                                z_normalized
);
    import obb_pkg::*;

    logic [CFG_W-1:0] thr_reg;
    logic [CFG_W-1:0] tol_reg;
    logic             vld_reg [PIPE_DEPTH];
    logic             adv;

    // front: dot products and projection dividends
    vec_t [1:0]         v0_reg, v1_reg, v2_reg, v3_reg;
    vec_t               z0_reg, z1_reg, z2_reg, z3_reg;
    logic signed [63:0] dp_reg   [2][3];
    logic signed [63:0] dp_next  [2][3];
    logic [63:0]        zsq_reg  [3];
    logic [63:0]        zsq_next [3];
    logic signed [63:0] dot_reg  [2];
    logic signed [63:0] dot_next [2];
    logic [63:0]        zz2_reg, zz3_reg, zz4_reg;
    logic [63:0]        zz_next;
    logic [63:0]        dmag     [2];
    logic [63:0]        pl_reg   [2][3];
    logic [63:0]        pl_next  [2][3];
    logic [63:0]        ph_reg   [2][3];
    logic [63:0]        ph_next  [2][3];
    logic [1:0][2:0]    neg3_reg;
    logic [1:0][2:0]    neg3_next;
    logic [DVD_W-1:0]   dvd_reg  [6];
    logic [DVD_W-1:0]   dvd_next [6];
    proj_side_t         ps4_reg;
    proj_side_t         d1_reg   [DIV_STAGES];
    proj_side_t         d1_out;
    logic [QUO_W-1:0]   quo1     [6];

    // middle: replacement of parallel axes
    vec_t [1:0]         p5_reg;
    vec_t [1:0]         p5_next;
    vec_t               z5_reg;
    logic [63:0]        sq6_reg  [2][3];
    logic [63:0]        sq6_next [2][3];
    logic signed [63:0] ca6_reg  [3];
    logic signed [63:0] ca6_next [3];
    logic signed [63:0] cb6_reg  [3];
    logic signed [63:0] cb6_next [3];
    vec_t [1:0]         p6_reg, p7_reg;
    vec_t               z6_reg, z7_reg;
    logic [63:0]        sl7_reg  [2];
    logic [63:0]        sl7_next [2];
    vec_t               cx7_reg, cx7_next;
    vec_t               x8_reg, x8_next, x9_reg, x10_reg;
    vec_t               y8_reg, y9_reg, y10_reg, y10_next;
    vec_t               z8_reg, z9_reg, z10_reg;
    logic               repy8_reg, repy8_next, repy9_reg;
    logic signed [63:0] ca9_reg  [3];
    logic signed [63:0] ca9_next [3];
    logic signed [63:0] cb9_reg  [3];
    logic signed [63:0] cb9_next [3];

    // back: lengths and normalization
    basis_t             b10, b11_reg, b12_reg;
    logic [63:0]        sq11_reg  [3][3];
    logic [63:0]        sq11_next [3][3];
    logic [63:0]        ss12_reg  [3];
    logic [63:0]        ss12_next [3];
    logic [2:0]         nf12_reg, nf12_next;
    logic [SQ_OUT_W-1:0] len      [3];
    norm_side_t         d2_reg    [SQRT_STAGES];
    norm_side_t         d3_reg    [DIV_STAGES];
    norm_side_t         d2_out, d3_out;
    logic [QUO_W-1:0]   quo2      [9];
    basis_t             ob_reg, ob_next;
    logic [2:0]         onf_reg;

    assign adv       = !vld_reg[PIPE_DEPTH-1] || out_ready;
    assign in_ready  = adv;
    assign out_valid = vld_reg[PIPE_DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
            tol_reg <= TOL_RESET;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_idx)
                CFG_PARALLEL:  thr_reg <= cfg_wdata;
                CFG_TOLERANCE: tol_reg <= cfg_wdata;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PIPE_DEPTH; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < PIPE_DEPTH; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    assign d1_out = d1_reg[DIV_STAGES-1];
    assign d2_out = d2_reg[SQRT_STAGES-1];
    assign d3_out = d3_reg[DIV_STAGES-1];
    assign b10    = {z10_reg, y10_reg, x10_reg};

    always_comb
    begin
        logic [QUO_W+1:0]   tq;
        logic signed [QUO_W+1:0] t;
        logic signed [QUO_W+1:0] diff;
        logic signed [65:0] w;
        comp_t              q;
        // dot products of X and Y with Z, and squares of Z
        for (int a = 0; a < 2; a++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                dp_next[a][i] = $signed(v0_reg[a][i]) * $signed(z0_reg[i]);
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            zsq_next[i] = $signed(z0_reg[i]) * $signed(z0_reg[i]);
        end
        for (int a = 0; a < 2; a++)
        begin
            dot_next[a] = sat_add(sat_add(dp_reg[a][0], dp_reg[a][1]), dp_reg[a][2]);
        end
        zz_next = zsq_reg[0] + zsq_reg[1] + zsq_reg[2];

        // |dot| * |z_i| split in two 32x32 products
        for (int a = 0; a < 2; a++)
        begin
            dmag[a] = dot_reg[a][63] ? 64'(0) - dot_reg[a] : dot_reg[a];
            for (int i = 0; i < 3; i++)
            begin
                pl_next[a][i]   = dmag[a][31:0] * mag_comp(z2_reg[i]);
                ph_next[a][i]   = {1'b0, dmag[a][62:32]} * mag_comp(z2_reg[i]);
                neg3_next[a][i] = dot_reg[a][63] ^ z2_reg[i][COMP_W-1];
            end
        end
        for (int a = 0; a < 2; a++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                dvd_next[a*3+i] = ({32'b0, ph_reg[a][i]} << 32) + {32'b0, pl_reg[a][i]};
            end
        end

        // subtract the projection, zero reference axis leaves the vector as is
        for (int a = 0; a < 2; a++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                tq   = {2'b00, quo1[a*3+i]};
                t    = d1_out.neg[a][i] ? -$signed(tq) : $signed(tq);
                diff = $signed({{2{d1_out.v[a][i][COMP_W-1]}}, d1_out.v[a][i]}) - t;
                w    = diff;
                p5_next[a][i] = d1_out.zz0 ? d1_out.v[a][i] : clamp_comp(w);
            end
        end

        // squared lengths of projected axes and products of Y cross Z
        for (int a = 0; a < 2; a++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sq6_next[a][i] = $signed(p5_reg[a][i]) * $signed(p5_reg[a][i]);
            end
        end
        for (int r = 0; r < 3; r++)
        begin
            ca6_next[r] = $signed(p5_reg[1][NXT1[r]]) * $signed(z5_reg[NXT2[r]]);
            cb6_next[r] = $signed(p5_reg[1][NXT2[r]]) * $signed(z5_reg[NXT1[r]]);
        end
        for (int a = 0; a < 2; a++)
        begin
            sl7_next[a] = sq6_reg[a][0] + sq6_reg[a][1] + sq6_reg[a][2];
        end
        for (int r = 0; r < 3; r++)
        begin
            cx7_next[r] = cross_term(ca6_reg[r], cb6_reg[r]);
        end
        x8_next    = (sl7_reg[0] < {1'b0, thr_reg}) ? cx7_reg : p7_reg[0];
        repy8_next = sl7_reg[1] < {1'b0, thr_reg};

        // X cross Z with the final X, to replace a parallel Y
        for (int r = 0; r < 3; r++)
        begin
            ca9_next[r] = $signed(x8_reg[NXT1[r]]) * $signed(z8_reg[NXT2[r]]);
            cb9_next[r] = $signed(x8_reg[NXT2[r]]) * $signed(z8_reg[NXT1[r]]);
        end
        for (int r = 0; r < 3; r++)
        begin
            y10_next[r] = repy9_reg ? cross_term(ca9_reg[r], cb9_reg[r]) : y9_reg[r];
        end

        // squared lengths of the three final vectors
        for (int j = 0; j < 3; j++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sq11_next[j][i] = $signed(b10[j][i]) * $signed(b10[j][i]);
            end
        end
        for (int j = 0; j < 3; j++)
        begin
            ss12_next[j] = sq11_reg[j][0] + sq11_reg[j][1] + sq11_reg[j][2];
            nf12_next[j] = ss12_next[j] > {1'b0, tol_reg};
        end

        // scaled components, sign restored; vectors not normalized pass through
        for (int j = 0; j < 3; j++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                q = quo2[j*3+i];
                if (d3_out.nf[j])
                begin
                    ob_next[j][i] = d3_out.b[j][i][COMP_W-1] ? COMP_W'(0) - q : q;
                end
                else
                begin
                    ob_next[j][i] = d3_out.b[j][i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            v0_reg   <= {{ya_z, ya_y, ya_x}, {xa_z, xa_y, xa_x}};
            z0_reg   <= {za_z, za_y, za_x};

            dp_reg   <= dp_next;
            zsq_reg  <= zsq_next;
            v1_reg   <= v0_reg;
            z1_reg   <= z0_reg;

            dot_reg  <= dot_next;
            zz2_reg  <= zz_next;
            v2_reg   <= v1_reg;
            z2_reg   <= z1_reg;

            pl_reg   <= pl_next;
            ph_reg   <= ph_next;
            neg3_reg <= neg3_next;
            zz3_reg  <= zz2_reg;
            v3_reg   <= v2_reg;
            z3_reg   <= z2_reg;

            dvd_reg  <= dvd_next;
            zz4_reg  <= zz3_reg;
            ps4_reg  <= '{v: v3_reg, z: z3_reg, neg: neg3_reg, zz0: (zz3_reg == 64'd0)};

            d1_reg[0] <= ps4_reg;
            for (int k = 1; k < DIV_STAGES; k++)
            begin
                d1_reg[k] <= d1_reg[k-1];
            end

            p5_reg   <= p5_next;
            z5_reg   <= d1_out.z;

            sq6_reg  <= sq6_next;
            ca6_reg  <= ca6_next;
            cb6_reg  <= cb6_next;
            p6_reg   <= p5_reg;
            z6_reg   <= z5_reg;

            sl7_reg  <= sl7_next;
            cx7_reg  <= cx7_next;
            p7_reg   <= p6_reg;
            z7_reg   <= z6_reg;

            x8_reg    <= x8_next;
            y8_reg    <= p7_reg[1];
            z8_reg    <= z7_reg;
            repy8_reg <= repy8_next;

            ca9_reg   <= ca9_next;
            cb9_reg   <= cb9_next;
            x9_reg    <= x8_reg;
            y9_reg    <= y8_reg;
            z9_reg    <= z8_reg;
            repy9_reg <= repy8_reg;

            x10_reg  <= x9_reg;
            y10_reg  <= y10_next;
            z10_reg  <= z9_reg;

            sq11_reg <= sq11_next;
            b11_reg  <= b10;

            ss12_reg <= ss12_next;
            nf12_reg <= nf12_next;
            b12_reg  <= b11_reg;

            d2_reg[0] <= '{b: b12_reg, nf: nf12_reg};
            for (int k = 1; k < SQRT_STAGES; k++)
            begin
                d2_reg[k] <= d2_reg[k-1];
            end
            d3_reg[0] <= d2_out;
            for (int k = 1; k < DIV_STAGES; k++)
            begin
                d3_reg[k] <= d3_reg[k-1];
            end

            ob_reg  <= ob_next;
            onf_reg <= d3_out.nf;
        end
    end

    for (genvar g = 0; g < 6; g++)
    begin : g_proj_div
        obb_div u_div (
            .clk      (clk),
            .en       (adv),
            .dividend (dvd_reg[g]),
            .divisor  (zz4_reg),
            .quotient (quo1[g])
        );
    end

    for (genvar j = 0; j < 3; j++)
    begin : g_len
        obb_isqrt u_sqrt (
            .clk      (clk),
            .en       (adv),
            .radicand (ss12_reg[j]),
            .root     (len[j])
        );
        for (genvar i = 0; i < 3; i++)
        begin : g_norm_div
            obb_div u_div (
                .clk      (clk),
                .en       (adv),
                .dividend (DVD_W'(mag_comp(d2_out.b[j][i])) << FRAC_BITS),
                .divisor  (DSR_W'(len[j])),
                .quotient (quo2[j*3+i])
            );
        end
    end

    assign bx_x = ob_reg[0][0];
    assign bx_y = ob_reg[0][1];
    assign bx_z = ob_reg[0][2];
    assign by_x = ob_reg[1][0];
    assign by_y = ob_reg[1][1];
    assign by_z = ob_reg[1][2];
    assign bz_x = ob_reg[2][0];
    assign bz_y = ob_reg[2][1];
    assign bz_z = ob_reg[2][2];
    assign x_normalized = onf_reg[0];
    assign y_normalized = onf_reg[1];
    assign z_normalized = onf_reg[2];

    // a normalized vector never leaves the unit range
    ast_x_unit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && x_normalized |->
            bx_x <= UNIT_POS && bx_x >= UNIT_NEG && bx_y <= UNIT_POS &&
            bx_y >= UNIT_NEG && bx_z <= UNIT_POS && bx_z >= UNIT_NEG)
        else $error("x basis vector outside unit range");

    ast_y_unit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && y_normalized |->
            by_x <= UNIT_POS && by_x >= UNIT_NEG && by_y <= UNIT_POS &&
            by_y >= UNIT_NEG && by_z <= UNIT_POS && by_z >= UNIT_NEG)
        else $error("y basis vector outside unit range");

    ast_z_unit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && z_normalized |->
            bz_x <= UNIT_POS && bz_x >= UNIT_NEG && bz_y <= UNIT_POS &&
            bz_y >= UNIT_NEG && bz_z <= UNIT_POS && bz_z >= UNIT_NEG)
        else $error("z basis vector outside unit range");

endmodule
